// ===== design/pngunf_pkg.sv =====
// Package for the PNG scanline unfilter: payload structs, register and
// filter codes, and the entry that the front end hands to the back end.
// Used by the FIFO, front end, back end and top; depends on nothing.
package pngunf_pkg;

  // Depth of the request queue between front end and back end.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH   = 2'd0,
    CFG_CHANNEL_COUNT = 2'd1,
    CFG_IMAGE_HEIGHT  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_e;

  localparam logic [7:0] MaxFilterCode = 8'd4;

  typedef struct packed {
    logic       start_of_image;
    logic [7:0] filtered_byte;
  } in_t;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic [1:0] channel_index;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;
  } out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] value;
  } cfg_t;

  // Raw register contents as written through the configuration port.
  typedef struct packed {
    logic [12:0] image_width;
    logic [2:0]  channel_count;
    logic [15:0] image_height;
  } settings_t;

  // One classified request for the back end. The row store address
  // travels next to it because its width follows the block parameters.
  typedef struct packed {
    logic       bad;        // bad filter type report, no pixel
    logic       first;      // first data byte of a scanline
    logic       row0;       // scanline 0, so the upper row reads as zero
    filter_e    filt;
    logic [1:0] ch;
    logic [7:0] data;
    logic       row_end;
    logic       image_end;
  } entry_t;

endpackage

// ===== design/pngunf_stream_if.sv =====
// Valid/ready channel used for the input, output and configuration ports.
// The payload type is set per instance; depends on nothing.
interface pngunf_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== design/pngunf_fifo.sv =====
// Short request queue between the front end and the back end.
// Depends on pngunf_pkg for its depth.
module pngunf_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o
);
  import pngunf_pkg::*;

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  logic [Width-1:0] slot_q [QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CntW'(QueueDepth));
  assign valid_o = (count_q != '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(QueueDepth))
    else $error("request queue holds more entries than it has slots");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("request pushed into a full queue");

endmodule

// ===== design/pngunf_front.sv =====
// Front end of the unfilter: accepts bytes, tracks filter type, column,
// channel, row and error state, and emits one classified request per result.
// Depends on pngunf_pkg and pngunf_stream_if.
module pngunf_front #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4,
  localparam int unsigned IdxW        = $clog2(MAX_WIDTH * MAX_CHANNELS)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pngunf_stream_if.sink         in_i,
  input  pngunf_pkg::settings_t settings_i,
  input  logic                  full_i,
  output logic                  push_o,
  output pngunf_pkg::entry_t    entry_o,
  output logic [IdxW-1:0]       idx_o
);
  import pngunf_pkg::*;

  localparam int unsigned ColW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned EW   = ($clog2(MAX_WIDTH + 1) > 13) ? $clog2(MAX_WIDTH + 1) : 13;

  logic            err_q, err_d, exp_q, exp_d;
  filter_e         filt_q, filt_d;
  logic [ColW-1:0] col_q, col_d, col;
  logic [1:0]      chn_q, chn_d, chn;
  logic [15:0]     row_q, row_d, row;
  logic            err, exp_flt, sof, accept, produce;
  logic [7:0]      byte_in;
  logic [2:0]      eff_nc;
  logic [EW-1:0]   eff_w;
  logic [16:0]     eff_h;
  logic            last_px, last_row, last_img;

  assign accept    = in_i.valid && in_i.ready;
  assign in_i.ready = !full_i;
  assign sof       = in_i.data.start_of_image;
  assign byte_in   = in_i.data.filtered_byte;

  // Out-of-range register values are clamped to the nearest legal one.
  always_comb begin
    if (settings_i.channel_count < 3'd3) begin
      eff_nc = 3'd3;
    end else if (settings_i.channel_count > 3'(MAX_CHANNELS)) begin
      eff_nc = 3'(MAX_CHANNELS);
    end else begin
      eff_nc = settings_i.channel_count;
    end
    if (settings_i.image_width == '0) begin
      eff_w = EW'(1);
    end else if (EW'(settings_i.image_width) > EW'(MAX_WIDTH)) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(settings_i.image_width);
    end
    eff_h = (settings_i.image_height == '0) ? 17'd1 : {1'b0, settings_i.image_height};
  end

  always_comb begin
    err     = sof ? 1'b0 : err_q;
    exp_flt = sof ? 1'b1 : exp_q;
    col     = sof ? '0 : col_q;
    chn     = sof ? '0 : chn_q;
    row     = sof ? '0 : row_q;

    last_px  = ({1'b0, chn} + 3'd1) >= eff_nc;
    last_row = last_px && ((EW'(col) + EW'(1)) >= eff_w);
    last_img = last_row && (({1'b0, row} + 17'd1) >= eff_h);

    err_d   = err;
    exp_d   = exp_flt;
    filt_d  = filt_q;
    col_d   = col;
    chn_d   = chn;
    row_d   = row;
    produce = 1'b0;

    entry_o           = '0;
    entry_o.bad       = 1'b0;
    entry_o.first     = (col == '0) && (chn == '0);
    entry_o.row0      = (row == '0);
    entry_o.filt      = filt_q;
    entry_o.ch        = chn;
    entry_o.data      = byte_in;
    entry_o.row_end   = last_row;
    entry_o.image_end = last_img;
    idx_o = IdxW'(IdxW'(col) * IdxW'(eff_nc) + IdxW'(chn));

    if (!err) begin
      if (exp_flt) begin
        if (byte_in > MaxFilterCode) begin
          produce = 1'b1;
          err_d   = 1'b1;
          entry_o = '0;
          entry_o.bad = 1'b1;
        end else begin
          filt_d = filter_e'(byte_in[2:0]);
          exp_d  = 1'b0;
        end
      end else begin
        produce = 1'b1;
        if (last_row) begin
          col_d = '0;
          chn_d = '0;
          exp_d = 1'b1;
          row_d = last_img ? '0 : row + 16'd1;
        end else if (last_px) begin
          chn_d = '0;
          col_d = col + 1'b1;
        end else begin
          chn_d = chn + 2'd1;
        end
      end
    end
  end

  assign push_o = accept && produce;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_q  <= 1'b0;
      exp_q  <= 1'b1;
      filt_q <= FILT_NONE;
      col_q  <= '0;
      chn_q  <= '0;
      row_q  <= '0;
    end else if (accept) begin
      err_q  <= err_d;
      exp_q  <= exp_d;
      filt_q <= filt_d;
      col_q  <= col_d;
      chn_q  <= chn_d;
      row_q  <= row_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.bad |=> err_q)
    else $error("bad filter report did not set the sticky error");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o && entry_o.image_end |-> entry_o.row_end && !entry_o.bad)
    else $error("image end marked on a byte that does not end a scanline");

endmodule

// ===== design/pngunf_back.sv =====
// Back end of the unfilter: reads the upper byte from the row store,
// predicts and reconstructs the byte, writes it back and registers the result.
// Depends on pngunf_pkg and pngunf_stream_if.
module pngunf_back #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4,
  localparam int unsigned Depth       = MAX_WIDTH * MAX_CHANNELS,
  localparam int unsigned IdxW        = $clog2(Depth)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  pngunf_pkg::entry_t q_entry_i,
  input  logic [IdxW-1:0]    q_idx_i,
  output logic               q_pop_o,
  pngunf_stream_if.source    out_o
);
  import pngunf_pkg::*;

  logic [7:0]      row_store [Depth];
  logic [7:0]      rd_q;
  logic            s_valid_q;
  entry_t          s_ent_q;
  logic [IdxW-1:0] s_idx_q;
  logic            o_valid_q;
  out_t            o_data_q, o_data_d;
  logic [7:0]      left_q [4];
  logic [7:0]      left_d [4];
  logic [7:0]      ul_q [4];
  logic [7:0]      ul_d [4];

  logic            o_free, s_adv, s_free, wr_en;
  logic [7:0]      a, b, c, pred, val;
  logic [8:0]      avg_sum;
  logic signed [9:0] dbc, dac, dsum;
  logic [9:0]      pa, pb, pc;

  function automatic logic [9:0] mag10(input logic signed [9:0] v);
    mag10 = v[9] ? 10'(-v) : 10'(v);
  endfunction

  assign o_free  = !o_valid_q || out_o.ready;
  assign s_adv   = s_valid_q && o_free;
  assign s_free  = !s_valid_q || s_adv;
  assign q_pop_o = q_valid_i && s_free;
  assign wr_en   = s_adv && !s_ent_q.bad;

  // Neighbors from the previous pixel are zero at the start of a scanline.
  assign a = s_ent_q.first ? 8'd0 : left_q[s_ent_q.ch];
  assign c = s_ent_q.first ? 8'd0 : ul_q[s_ent_q.ch];
  assign b = s_ent_q.row0 ? 8'd0 : rd_q;

  assign avg_sum = {1'b0, a} + {1'b0, b};
  assign dbc     = $signed({2'b00, b}) - $signed({2'b00, c});
  assign dac     = $signed({2'b00, a}) - $signed({2'b00, c});
  assign dsum    = dbc + dac;
  assign pa      = mag10(dbc);
  assign pb      = mag10(dac);
  assign pc      = mag10(dsum);

  always_comb begin
    unique case (s_ent_q.filt)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = avg_sum[8:1];
      FILT_PAETH: begin
        if (pa <= pb && pa <= pc) begin
          pred = a;
        end else if (pb <= pc) begin
          pred = b;
        end else begin
          pred = c;
        end
      end
      default:    pred = 8'd0;
    endcase
    val = s_ent_q.data + pred;
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      left_d[i] = s_ent_q.first ? 8'd0 : left_q[i];
      ul_d[i]   = s_ent_q.first ? 8'd0 : ul_q[i];
    end
    left_d[s_ent_q.ch] = val;
    ul_d[s_ent_q.ch]   = b;

    o_data_d = '0;
    if (s_ent_q.bad) begin
      o_data_d.bad_filter = 1'b1;
    end else begin
      o_data_d.pixel_byte    = val;
      o_data_d.channel_index = s_ent_q.ch;
      o_data_d.row_end       = s_ent_q.row_end;
      o_data_d.image_end     = s_ent_q.image_end;
    end
  end

  // Row store: one read for the request entering the stage, one write
  // for the byte leaving it.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      rd_q <= row_store[q_idx_i];
    end
    if (wr_en) begin
      row_store[s_idx_q] <= val;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      s_ent_q <= q_entry_i;
      s_idx_q <= q_idx_i;
    end
    if (s_adv) begin
      o_data_q <= o_data_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      for (int i = 0; i < 4; i++) begin
        left_q[i] <= 8'd0;
        ul_q[i]   <= 8'd0;
      end
    end else begin
      if (s_free) begin
        s_valid_q <= q_valid_i;
      end
      if (o_free) begin
        o_valid_q <= s_valid_q;
      end
      if (wr_en) begin
        left_q <= left_d;
        ul_q   <= ul_d;
      end
    end
  end

  assign out_o.valid = o_valid_q;
  assign out_o.data  = o_data_q;

  // A byte that needs the upper row never reads the entry being written.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o && wr_en && !q_entry_i.bad && !q_entry_i.row0 |-> q_idx_i != s_idx_q)
    else $error("row store read collides with the pending write");

endmodule

// ===== design/png_scanline_unfilter.sv =====
// PNG scanline unfilter for 8-bit RGB/RGBA. It takes one inflated byte per
// cycle on in_i and sustains one byte per cycle while out_o is ready and the
// request queue is not full; each data byte passes the request queue, the row
// store read stage and the output register on its way to out_o, and filter
// type bytes give no result unless the type is above 4. The rate rests on the
// combinational predictor and the row store, which is read once and written
// once each cycle. The row store holds MAX_WIDTH * MAX_CHANNELS bytes and needs
// no clearing pass after reset, since the first scanline of an image never
// reads it. Registers on cfg_i are meant to change only between images.
module png_scanline_unfilter #(
  parameter int unsigned MAX_WIDTH    = 4096,
  parameter int unsigned MAX_CHANNELS = 4
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  pngunf_stream_if.sink   in_i,
  pngunf_stream_if.source out_o,
  pngunf_stream_if.sink   cfg_i
);
  import pngunf_pkg::*;

  localparam int unsigned IdxW   = $clog2(MAX_WIDTH * MAX_CHANNELS);
  localparam int unsigned EntryW = $bits(entry_t);
  localparam int unsigned QW     = IdxW + EntryW;

  settings_t       settings_q;
  logic            push, full, q_valid, q_pop;
  entry_t          push_entry, q_entry;
  logic [IdxW-1:0] push_idx, q_idx;
  logic [QW-1:0]   q_in, q_out;
  cfg_t            cfg_req;

  assign cfg_i.ready = 1'b1;
  assign cfg_req     = cfg_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q.image_width   <= 13'd1;
      settings_q.channel_count <= 3'd4;
      settings_q.image_height  <= 16'd1;
    end else if (cfg_i.valid) begin
      unique case (cfg_req.index)
        CFG_IMAGE_WIDTH:   settings_q.image_width   <= cfg_req.value[12:0];
        CFG_CHANNEL_COUNT: settings_q.channel_count <= cfg_req.value[2:0];
        CFG_IMAGE_HEIGHT:  settings_q.image_height  <= cfg_req.value;
        default: ;
      endcase
    end
  end

  pngunf_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .settings_i (settings_q),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry),
    .idx_o      (push_idx)
  );

  assign q_in    = {push_idx, push_entry};
  assign q_idx   = q_out[QW-1:EntryW];
  assign q_entry = entry_t'(q_out[EntryW-1:0]);

  pngunf_fifo #(
    .Width (QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_in),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .data_o  (q_out)
  );

  pngunf_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_entry_i (q_entry),
    .q_idx_i   (q_idx),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule
